>>> src/preemptive_priority_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler unit
// Same-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared widths, codes and types of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int OTIME_W = 16;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    // One slot of the process table as held in memory.
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] remaining;
    } t_slot_rec;

endpackage

>>> src/pss_in_if.sv
// ----------------------------------------------------------------------------
// pss_in_if
// Request channel: load, tick and clear beats with valid/ready.
// ----------------------------------------------------------------------------
interface pss_in_if;
    import pss_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot;
    logic [ARR_W-1:0]    arrival;
    logic [BURST_W-1:0]  burst;
    logic [PRIO_W-1:0]   priority_req;

    modport source (
        output valid, mode, slot, arrival, burst, priority_req,
        input  ready
    );

    modport sink (
        input  valid, mode, slot, arrival, burst, priority_req,
        output ready
    );
endinterface

>>> src/pss_out_if.sv
// ----------------------------------------------------------------------------
// pss_out_if
// Result channel: one beat per tick with valid/ready.
// ----------------------------------------------------------------------------
interface pss_out_if;
    import pss_pkg::*;

    logic                valid;
    logic                ready;
    logic                idle;
    logic [SLOT_W-1:0]   served_slot;
    logic                finished;
    logic [OTIME_W-1:0]  completion_time;
    logic [OTIME_W-1:0]  turnaround;
    logic [OTIME_W-1:0]  waiting;
    logic                all_done;

    modport source (
        output valid, idle, served_slot, finished, completion_time, turnaround,
               waiting, all_done,
        input  ready
    );

    modport sink (
        input  valid, idle, served_slot, finished, completion_time, turnaround,
               waiting, all_done,
        output ready
    );
endinterface

>>> src/pss_ram.sv
// ----------------------------------------------------------------------------
// pss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Preemptive priority scheduler over a memory-held table of process slots.
//
//   channel  dir  beat content
//   i_in     in   mode, slot, arrival, burst, priority_req
//   o_out    out  idle, served_slot, finished, completion_time, turnaround,
//                 waiting, all_done
//
// A load or clear beat is taken in idle. A tick beat is accepted in idle,
// then every slot is streamed out of the table RAM past one priority
// comparator, and then the served slot is written back.
// Reset is synchronous, active low; the table RAM needs no clearing pass.
// A result waits in the output register while new beats are taken; a tick
// stalls in its write-back cycle only while that register is still full.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_unit_assert.svh"

module preemptive_priority_scheduler_unit #(
    parameter int MAX_PROCS = pss_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = pss_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pss_in_if.sink      i_in,
    pss_out_if.source   o_out
);
    import pss_pkg::*;

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int CMP_W  = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;
    localparam int REC_W  = $bits(t_slot_rec);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0]     LAST_CNT = CNT_W'(MAX_PROCS);

    // Control state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [MAX_PROCS-1:0]   r_pend, n_pend;   // valid and remaining time left
    logic [TIME_BITS-1:0]   r_time;
    logic [TIME_BITS-1:0]   r_ct;             // saturated clock plus one

    // Best candidate of the running scan
    logic                   r_best_found;
    logic [IDX_W-1:0]       r_best_idx;
    logic [PRIO_W-1:0]      r_best_prio;
    logic [ARR_W-1:0]       r_best_arr;
    logic [BURST_W-1:0]     r_best_burst;
    logic [BURST_W-1:0]     r_best_rem;
    logic [CMP_W-1:0]       r_best_ta;

    // Output register
    logic                   r_o_valid;
    logic                   r_o_idle;
    logic [SLOT_W-1:0]      r_o_slot;
    logic                   r_o_fin;
    logic [OTIME_W-1:0]     r_o_ct;
    logic [OTIME_W-1:0]     r_o_ta;
    logic [OTIME_W-1:0]     r_o_wt;
    logic                   r_o_all_done;

    // Handshake and step decode
    logic in_ready, in_acc, tick_acc, load_acc, clear_acc, slot_ok;
    logic issue, out_free, commit;

    // RAM port
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    t_slot_rec        ram_wdata, rd;
    logic [REC_W-1:0] ram_rdata;

    // Scan compare and write-back math
    logic             cand;
    logic [CMP_W-1:0] cand_ta;
    logic             fin;
    logic [CMP_W-1:0] burst_ext;

    pss_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == LAST_CNT) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        commit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_SCAN: begin
                issue = (r_cnt < LAST_CNT);
            end
            S_UPDATE: begin
                commit = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_acc    = i_in.valid && in_ready;
    assign tick_acc  = in_acc && (i_in.mode == MODE_TICK);
    assign load_acc  = in_acc && (i_in.mode == MODE_LOAD);
    assign clear_acc = in_acc && (i_in.mode == MODE_CLEAR);
    assign slot_ok   = (int'(i_in.slot) < MAX_PROCS);
    assign out_free  = !r_o_valid || o_out.ready;

    // ------------------------------------------------------------------
    // Table RAM: loads write in idle, the served slot is written back at
    // commit; the scan only reads, so the two never meet on one entry.
    // ------------------------------------------------------------------
    assign ram_re    = issue;
    assign ram_raddr = r_cnt[IDX_W-1:0];
    assign ram_we    = (load_acc && slot_ok) || (commit && r_best_found);
    assign ram_waddr = commit ? r_best_idx : IDX_W'(i_in.slot);

    always_comb begin
        if (commit) begin
            ram_wdata.arrival   = r_best_arr;
            ram_wdata.burst     = r_best_burst;
            ram_wdata.prio      = r_best_prio;
            ram_wdata.remaining = r_best_rem - BURST_W'(1);
        end else begin
            ram_wdata.arrival   = i_in.arrival;
            ram_wdata.burst     = i_in.burst;
            ram_wdata.prio      = i_in.priority_req;
            ram_wdata.remaining = i_in.burst;
        end
    end

    // ------------------------------------------------------------------
    // Scan compare: a pending, arrived slot beats the held one only on a
    // strictly lower priority, so ties keep the lower slot.
    // ------------------------------------------------------------------
    assign rd      = t_slot_rec'(ram_rdata);
    assign cand    = r_rd_vld && r_pend[r_rd_idx]
                     && (CMP_W'(rd.arrival) <= CMP_W'(r_time))
                     && (!r_best_found || (rd.prio < r_best_prio));
    assign cand_ta = CMP_W'(r_ct) - CMP_W'(rd.arrival);

    assign fin       = r_best_found && (r_best_rem == BURST_W'(1));
    assign burst_ext = CMP_W'(r_best_burst);

    // Pending flags after this cycle's load, clear or completion
    always_comb begin
        n_pend = r_pend;
        if (load_acc && slot_ok) begin
            n_pend[IDX_W'(i_in.slot)] = (i_in.burst != '0);
        end
        if (clear_acc) begin
            n_pend = '0;
        end
        if (commit && fin) begin
            n_pend[r_best_idx] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_rd_vld     <= 1'b0;
            r_pend       <= '0;
            r_time       <= '0;
            r_best_found <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r_pend   <= n_pend;
            if (tick_acc) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            // hold the clock at its maximum
            if (clear_acc) begin
                r_time <= '0;
            end else if (commit) begin
                r_time <= r_ct;
            end
            if (tick_acc) begin
                r_best_found <= 1'b0;
            end else if (cand) begin
                r_best_found <= 1'b1;
            end
            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[IDX_W-1:0];
        if (tick_acc) begin
            r_ct <= (r_time == TIME_MAX) ? r_time : r_time + TIME_BITS'(1);
        end
        if (cand) begin
            r_best_idx   <= r_rd_idx;
            r_best_prio  <= rd.prio;
            r_best_arr   <= rd.arrival;
            r_best_burst <= rd.burst;
            r_best_rem   <= rd.remaining;
            r_best_ta    <= cand_ta;
        end
        if (commit) begin
            r_o_idle     <= !r_best_found;
            r_o_slot     <= r_best_found ? SLOT_W'(r_best_idx) : '0;
            r_o_fin      <= fin;
            r_o_ct       <= fin ? OTIME_W'(r_ct) : '0;
            r_o_ta       <= fin ? OTIME_W'(r_best_ta) : '0;
            // drop a negative waiting time to zero
            r_o_wt       <= (fin && (r_best_ta >= burst_ext))
                            ? OTIME_W'(r_best_ta - burst_ext) : '0;
            r_o_all_done <= ~|n_pend;
        end
    end

    // ------------------------------------------------------------------
    // Port drive
    // ------------------------------------------------------------------
    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_o_valid;
    assign o_out.idle            = r_o_idle;
    assign o_out.served_slot     = r_o_slot;
    assign o_out.finished        = r_o_fin;
    assign o_out.completion_time = r_o_ct;
    assign o_out.turnaround      = r_o_ta;
    assign o_out.waiting         = r_o_wt;
    assign o_out.all_done        = r_o_all_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PSS_ASSERT_SAME(a_no_write_in_scan, i_clk, i_rst_n, r_state == S_SCAN, !ram_we, "table written during scan")
    `PSS_ASSERT_SAME(a_fin_not_idle, i_clk, i_rst_n, o_out.valid && o_out.finished, !o_out.idle, "finished beat marked idle")
    `PSS_ASSERT_SAME(a_slot_range, i_clk, i_rst_n, o_out.valid && !o_out.idle, int'(o_out.served_slot) < MAX_PROCS, "served slot out of range")
    `PSS_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, commit && fin, !r_pend[$past(r_best_idx)], "completed slot still pending")
endmodule
